// ===== hw/rtl/pairwise_close_encounter_detector_top_assert.svh =====
// ----------------------------------------------------------------------------
// close encounter detector assertion macros
// shared concurrent property wrappers for the top level
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_CLOSE_ENCOUNTER_DETECTOR_TOP_ASSERT_SVH
`define PAIRWISE_CLOSE_ENCOUNTER_DETECTOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcd assertion failed");

// antecedent implies consequent in the next cycle
`define PCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcd assertion failed");

`endif

// ===== hw/rtl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// close encounter detector package
// shared types, constants and the per-pair operation sequence
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int MAX_BODIES = 8;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);
    localparam int OUT_IDX_W  = 3;

    // wide multiply-accumulate geometry
    localparam int LIMB_W  = 32;
    localparam int LIMBS   = 10;
    localparam int BIG_W   = LIMBS * LIMB_W;
    localparam int B_LIMBS = 3;
    localparam int B_W     = B_LIMBS * LIMB_W;
    localparam int POS_W   = $clog2(LIMBS);
    localparam int K_W     = $clog2(B_LIMBS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HILL_FACTOR = 2'd0,
        REG_STEP_FACTOR = 2'd1,
        REG_TIME_STEP   = 2'd2
    } cfg_reg_t;

    localparam logic [7:0]  HILL_RESET  = 8'd48;
    localparam logic [7:0]  STEP_RESET  = 8'd48;
    localparam logic [31:0] TSTEP_RESET = 32'h0100_0000;

    localparam logic [63:0] SCALE_NINE = 64'd9;
    localparam logic [63:0] SCALE_24   = 64'h0000_0000_0100_0000;
    localparam logic [63:0] SCALE_56   = 64'h0100_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [31:0]        body_mass;
        logic               last_body;
    } in_item_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] first_index;
        logic [OUT_IDX_W-1:0] second_index;
        logic [63:0]          distance_squared;
        logic                 close_flag;
        logic                 any_close;
        logic                 pair_valid;
        logic                 last_pair;
    } out_item_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] mass;
    } body_t;

    typedef enum logic [4:0] {
        SRC_DX, SRC_DY, SRC_DZ, SRC_VX, SRC_VY, SRC_VZ,
        SRC_PXI, SRC_PYI, SRC_PZI, SRC_PXJ, SRC_PYJ, SRC_PZJ,
        SRC_D2, SRC_A2, SRC_V2, SRC_LHS, SRC_RHS,
        SRC_NINE, SRC_MC, SRC_P24, SRC_H3, SRC_MSUM, SRC_P56, SRC_TSTEP, SRC_S2
    } src_t;

    typedef enum logic [2:0] {
        DST_D2, DST_R1, DST_R2, DST_V2, DST_LHS, DST_RHS
    } dst_t;

    typedef enum logic [1:0] {
        K_MAC, K_CMP_A2, K_CMP_HILL, K_CMP_STEP
    } kind_t;

    typedef struct packed {
        kind_t kind;
        src_t  src_a;
        src_t  src_b;
        dst_t  dst;
        logic  acc;
    } uop_t;

    typedef enum logic [3:0] {
        S_LOAD, S_START, S_SCAN_RD, S_SCAN_CMP, S_RD_I, S_LAT_I, S_LAT_J,
        S_STEP, S_MAC_WAIT, S_EMIT
    } state_t;

    localparam int NUM_STEPS = 31;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    typedef struct packed {
        logic             load_we;
        logic [IDX_W-1:0] load_idx;
        logic [IDX_W-1:0] rd_addr;
        logic             scan_cmp;
        logic             scan_first;
        logic [IDX_W-1:0] scan_idx;
        logic             set_start;
        logic             latch_i;
        logic             latch_j;
        logic [IDX_W-1:0] pair_i;
        logic [IDX_W-1:0] pair_j;
        logic             mac_start;
        logic             cmp_en;
        uop_t             uop;
        logic             out_load;
        logic             out_empty;
        logic             out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mac_busy;
        logic mac_done;
    } ctrl_status_t;

    function automatic uop_t mk_uop(kind_t k, src_t a, src_t b, dst_t d, logic acc);
        uop_t u;
        u.kind  = k;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        u.acc   = acc;
        return u;
    endfunction

    // per-pair sequence: distance, origin radii, hill test, step test
    function automatic uop_t ucode(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            5'd0:  u = mk_uop(K_MAC, SRC_DX, SRC_DX, DST_D2, 1'b0);
            5'd1:  u = mk_uop(K_MAC, SRC_DY, SRC_DY, DST_D2, 1'b1);
            5'd2:  u = mk_uop(K_MAC, SRC_DZ, SRC_DZ, DST_D2, 1'b1);
            5'd3:  u = mk_uop(K_MAC, SRC_PXI, SRC_PXI, DST_R1, 1'b0);
            5'd4:  u = mk_uop(K_MAC, SRC_PYI, SRC_PYI, DST_R1, 1'b1);
            5'd5:  u = mk_uop(K_MAC, SRC_PZI, SRC_PZI, DST_R1, 1'b1);
            5'd6:  u = mk_uop(K_MAC, SRC_PXJ, SRC_PXJ, DST_R2, 1'b0);
            5'd7:  u = mk_uop(K_MAC, SRC_PYJ, SRC_PYJ, DST_R2, 1'b1);
            5'd8:  u = mk_uop(K_MAC, SRC_PZJ, SRC_PZJ, DST_R2, 1'b1);
            5'd9:  u = mk_uop(K_CMP_A2, SRC_D2, SRC_D2, DST_D2, 1'b0);
            5'd10: u = mk_uop(K_MAC, SRC_D2, SRC_D2, DST_LHS, 1'b0);
            5'd11: u = mk_uop(K_MAC, SRC_LHS, SRC_D2, DST_LHS, 1'b0);
            5'd12: u = mk_uop(K_MAC, SRC_LHS, SRC_NINE, DST_LHS, 1'b0);
            5'd13: u = mk_uop(K_MAC, SRC_LHS, SRC_MC, DST_LHS, 1'b0);
            5'd14: u = mk_uop(K_MAC, SRC_LHS, SRC_MC, DST_LHS, 1'b0);
            5'd15: u = mk_uop(K_MAC, SRC_LHS, SRC_P24, DST_LHS, 1'b0);
            5'd16: u = mk_uop(K_MAC, SRC_A2, SRC_A2, DST_RHS, 1'b0);
            5'd17: u = mk_uop(K_MAC, SRC_RHS, SRC_A2, DST_RHS, 1'b0);
            5'd18: u = mk_uop(K_MAC, SRC_RHS, SRC_H3, DST_RHS, 1'b0);
            5'd19: u = mk_uop(K_MAC, SRC_RHS, SRC_H3, DST_RHS, 1'b0);
            5'd20: u = mk_uop(K_MAC, SRC_RHS, SRC_MSUM, DST_RHS, 1'b0);
            5'd21: u = mk_uop(K_MAC, SRC_RHS, SRC_MSUM, DST_RHS, 1'b0);
            5'd22: u = mk_uop(K_CMP_HILL, SRC_D2, SRC_D2, DST_D2, 1'b0);
            5'd23: u = mk_uop(K_MAC, SRC_VX, SRC_VX, DST_V2, 1'b0);
            5'd24: u = mk_uop(K_MAC, SRC_VY, SRC_VY, DST_V2, 1'b1);
            5'd25: u = mk_uop(K_MAC, SRC_VZ, SRC_VZ, DST_V2, 1'b1);
            5'd26: u = mk_uop(K_MAC, SRC_D2, SRC_P56, DST_LHS, 1'b0);
            5'd27: u = mk_uop(K_MAC, SRC_V2, SRC_TSTEP, DST_RHS, 1'b0);
            5'd28: u = mk_uop(K_MAC, SRC_RHS, SRC_TSTEP, DST_RHS, 1'b0);
            5'd29: u = mk_uop(K_MAC, SRC_RHS, SRC_S2, DST_RHS, 1'b0);
            default: u = mk_uop(K_CMP_STEP, SRC_D2, SRC_D2, DST_D2, 1'b0);
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/pcd_mac.sv =====
// ----------------------------------------------------------------------------
// pcd wide multiply-accumulate
// r = r_init + a * b, one 32x32 limb product per cycle
// ----------------------------------------------------------------------------
module pcd_mac
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pcd_pkg::BIG_W-1:0]  a_in,
    input  logic [pcd_pkg::B_W-1:0]    b_in,
    input  logic [pcd_pkg::BIG_W-1:0]  r_init,
    output logic                       busy,
    output logic                       done,
    output logic [pcd_pkg::BIG_W-1:0]  result
);

    logic [pcd_pkg::LIMB_W-1:0] a_reg [pcd_pkg::LIMBS];
    logic [pcd_pkg::LIMB_W-1:0] b_reg [pcd_pkg::B_LIMBS];
    logic [pcd_pkg::LIMB_W-1:0] r_reg [pcd_pkg::LIMBS];
    logic [pcd_pkg::LIMB_W-1:0] carry_reg;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [pcd_pkg::K_W-1:0]   k_reg, k_next;
    logic [pcd_pkg::POS_W-1:0] l_reg, l_next;

    logic [pcd_pkg::POS_W-1:0] pos;
    logic [63:0]               prod;
    logic [63:0]               sum;
    logic                      row_end;
    logic                      last;

    assign pos     = pcd_pkg::POS_W'(k_reg) + l_reg;
    assign prod    = {32'd0, a_reg[l_reg]} * {32'd0, b_reg[k_reg]};
    assign sum     = prod + {32'd0, r_reg[pos]} + {32'd0, carry_reg};
    assign row_end = (pos == pcd_pkg::POS_W'(pcd_pkg::LIMBS - 1));
    assign last    = row_end && (k_reg == pcd_pkg::K_W'(pcd_pkg::B_LIMBS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        l_next    = l_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            l_next    = '0;
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (row_end)
            begin
                k_next = k_reg + 1'b1;
                l_next = '0;
            end
            else
            begin
                l_next = l_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
            l_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
            l_reg    <= l_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int g = 0; g < pcd_pkg::LIMBS; g++)
            begin
                a_reg[g] <= a_in[g*pcd_pkg::LIMB_W +: pcd_pkg::LIMB_W];
                r_reg[g] <= r_init[g*pcd_pkg::LIMB_W +: pcd_pkg::LIMB_W];
            end
            for (int g = 0; g < pcd_pkg::B_LIMBS; g++)
            begin
                b_reg[g] <= b_in[g*pcd_pkg::LIMB_W +: pcd_pkg::LIMB_W];
            end
            carry_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg[pos] <= sum[31:0];
            carry_reg  <= row_end ? '0 : sum[63:32];
        end
    end

    for (genvar g = 0; g < pcd_pkg::LIMBS; g++)
    begin : g_res
        assign result[g*pcd_pkg::LIMB_W +: pcd_pkg::LIMB_W] = r_reg[g];
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/pcd_datapath.sv =====
// ----------------------------------------------------------------------------
// pcd datapath
// body store, config registers, wide operands, compares and result register
// ----------------------------------------------------------------------------
module pcd_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  pcd_pkg::in_item_t                in_data,
    input  logic                             wr_en,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0]   wr_data,
    input  pcd_pkg::ctrl_cmd_t               cmd,
    output pcd_pkg::ctrl_status_t            status,
    output pcd_pkg::out_item_t               out_data
);

    // config
    logic [7:0]  hill_reg;
    logic [7:0]  step_reg;
    logic [31:0] tstep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hill_reg  <= pcd_pkg::HILL_RESET;
            step_reg  <= pcd_pkg::STEP_RESET;
            tstep_reg <= pcd_pkg::TSTEP_RESET;
        end
        else if (wr_en)
        begin
            case (pcd_pkg::cfg_reg_t'(wr_index))
                pcd_pkg::REG_HILL_FACTOR: hill_reg  <= wr_data[7:0];
                pcd_pkg::REG_STEP_FACTOR: step_reg  <= wr_data[7:0];
                pcd_pkg::REG_TIME_STEP:   tstep_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // factor powers, refreshed every cycle from stable config
    logic [15:0] h2_reg;
    logic [23:0] h3_reg;
    logic [15:0] s2_reg;

    always_ff @(posedge clk)
    begin
        h2_reg <= {8'd0, hill_reg} * {8'd0, hill_reg};
        h3_reg <= {8'd0, h2_reg} * {16'd0, hill_reg};
        s2_reg <= {8'd0, step_reg} * {8'd0, step_reg};
    end

    // body store
    pcd_pkg::body_t mem [pcd_pkg::MAX_BODIES];
    pcd_pkg::body_t mem_rd_reg;
    pcd_pkg::body_t wr_body;

    assign wr_body = '{pos_x: in_data.pos_x, pos_y: in_data.pos_y, pos_z: in_data.pos_z,
                       vel_x: in_data.vel_x, vel_y: in_data.vel_y, vel_z: in_data.vel_z,
                       mass: in_data.body_mass};

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            mem[cmd.load_idx] <= wr_body;
        end
        mem_rd_reg <= mem[cmd.rd_addr];
    end

    // central body search and pair latches
    logic [31:0]               mc_reg;
    logic [pcd_pkg::IDX_W-1:0] central_reg;
    pcd_pkg::body_t            bi_reg;
    pcd_pkg::body_t            bj_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_cmp && (cmd.scan_first || (mem_rd_reg.mass > mc_reg)))
        begin
            mc_reg      <= mem_rd_reg.mass;
            central_reg <= cmd.scan_idx;
        end
        if (cmd.latch_i)
        begin
            bi_reg <= mem_rd_reg;
        end
        if (cmd.latch_j)
        begin
            bj_reg <= mem_rd_reg;
        end
    end

    function automatic logic [32:0] diff_mag(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (33'd0 - d) : d;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] a);
        return a[31] ? (32'd0 - a) : a;
    endfunction

    logic [32:0] dx, dy, dz, vx, vy, vz;
    logic [32:0] msum;

    assign dx   = diff_mag(bi_reg.pos_x, bj_reg.pos_x);
    assign dy   = diff_mag(bi_reg.pos_y, bj_reg.pos_y);
    assign dz   = diff_mag(bi_reg.pos_z, bj_reg.pos_z);
    assign vx   = diff_mag(bi_reg.vel_x, bj_reg.vel_x);
    assign vy   = diff_mag(bi_reg.vel_y, bj_reg.vel_y);
    assign vz   = diff_mag(bi_reg.vel_z, bj_reg.vel_z);
    assign msum = {1'b0, bi_reg.mass} + {1'b0, bj_reg.mass};

    // wide working registers
    logic [pcd_pkg::BIG_W-1:0] d2_reg, r1_reg, r2_reg, v2_reg, lhs_reg, rhs_reg;
    logic                      a2_r1_reg;
    logic [pcd_pkg::BIG_W-1:0] a2;

    assign a2 = a2_r1_reg ? r1_reg : r2_reg;

    function automatic logic [pcd_pkg::BIG_W-1:0] src_val(input pcd_pkg::src_t s);
        logic [pcd_pkg::BIG_W-1:0] v;
        case (s)
            pcd_pkg::SRC_DX:    v = pcd_pkg::BIG_W'(dx);
            pcd_pkg::SRC_DY:    v = pcd_pkg::BIG_W'(dy);
            pcd_pkg::SRC_DZ:    v = pcd_pkg::BIG_W'(dz);
            pcd_pkg::SRC_VX:    v = pcd_pkg::BIG_W'(vx);
            pcd_pkg::SRC_VY:    v = pcd_pkg::BIG_W'(vy);
            pcd_pkg::SRC_VZ:    v = pcd_pkg::BIG_W'(vz);
            pcd_pkg::SRC_PXI:   v = pcd_pkg::BIG_W'(abs32(bi_reg.pos_x));
            pcd_pkg::SRC_PYI:   v = pcd_pkg::BIG_W'(abs32(bi_reg.pos_y));
            pcd_pkg::SRC_PZI:   v = pcd_pkg::BIG_W'(abs32(bi_reg.pos_z));
            pcd_pkg::SRC_PXJ:   v = pcd_pkg::BIG_W'(abs32(bj_reg.pos_x));
            pcd_pkg::SRC_PYJ:   v = pcd_pkg::BIG_W'(abs32(bj_reg.pos_y));
            pcd_pkg::SRC_PZJ:   v = pcd_pkg::BIG_W'(abs32(bj_reg.pos_z));
            pcd_pkg::SRC_D2:    v = d2_reg;
            pcd_pkg::SRC_A2:    v = a2;
            pcd_pkg::SRC_V2:    v = v2_reg;
            pcd_pkg::SRC_LHS:   v = lhs_reg;
            pcd_pkg::SRC_RHS:   v = rhs_reg;
            pcd_pkg::SRC_NINE:  v = pcd_pkg::BIG_W'(pcd_pkg::SCALE_NINE);
            pcd_pkg::SRC_MC:    v = pcd_pkg::BIG_W'(mc_reg);
            pcd_pkg::SRC_P24:   v = pcd_pkg::BIG_W'(pcd_pkg::SCALE_24);
            pcd_pkg::SRC_H3:    v = pcd_pkg::BIG_W'(h3_reg);
            pcd_pkg::SRC_MSUM:  v = pcd_pkg::BIG_W'(msum);
            pcd_pkg::SRC_P56:   v = pcd_pkg::BIG_W'(pcd_pkg::SCALE_56);
            pcd_pkg::SRC_TSTEP: v = pcd_pkg::BIG_W'(tstep_reg);
            pcd_pkg::SRC_S2:    v = pcd_pkg::BIG_W'(s2_reg);
            default:            v = '0;
        endcase
        return v;
    endfunction

    logic [pcd_pkg::BIG_W-1:0] dst_val;

    always_comb
    begin
        case (cmd.uop.dst)
            pcd_pkg::DST_D2:  dst_val = d2_reg;
            pcd_pkg::DST_R1:  dst_val = r1_reg;
            pcd_pkg::DST_R2:  dst_val = r2_reg;
            pcd_pkg::DST_V2:  dst_val = v2_reg;
            pcd_pkg::DST_LHS: dst_val = lhs_reg;
            pcd_pkg::DST_RHS: dst_val = rhs_reg;
            default:          dst_val = '0;
        endcase
    end

    logic [pcd_pkg::BIG_W-1:0] a_sel, b_sel, r_init, mac_result;
    logic                      mac_busy, mac_done;
    pcd_pkg::dst_t             wb_dst_reg;

    // operand select follows the working registers as they are written back
    always_comb
    begin
        a_sel = src_val(cmd.uop.src_a);
        b_sel = src_val(cmd.uop.src_b);
    end

    assign r_init = cmd.uop.acc ? dst_val : '0;

    pcd_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mac_start),
        .a_in   (a_sel),
        .b_in   (b_sel[pcd_pkg::B_W-1:0]),
        .r_init (r_init),
        .busy   (mac_busy),
        .done   (mac_done),
        .result (mac_result)
    );

    // compares
    logic lhs_lt_rhs;
    logic r1_lt_r2;
    logic pair_en;
    logic close_now;
    logic hill_ok_reg;
    logic close_reg;
    logic any_reg;

    assign lhs_lt_rhs = (lhs_reg < rhs_reg);
    assign r1_lt_r2   = (r1_reg < r2_reg);
    assign pair_en    = (mc_reg != 32'd0) && (cmd.pair_i != central_reg)
                        && (cmd.pair_j != central_reg);
    assign close_now  = pair_en && hill_ok_reg && lhs_lt_rhs;

    always_ff @(posedge clk)
    begin
        if (cmd.mac_start)
        begin
            wb_dst_reg <= cmd.uop.dst;
        end
        if (mac_done)
        begin
            case (wb_dst_reg)
                pcd_pkg::DST_D2:  d2_reg  <= mac_result;
                pcd_pkg::DST_R1:  r1_reg  <= mac_result;
                pcd_pkg::DST_R2:  r2_reg  <= mac_result;
                pcd_pkg::DST_V2:  v2_reg  <= mac_result;
                pcd_pkg::DST_LHS: lhs_reg <= mac_result;
                pcd_pkg::DST_RHS: rhs_reg <= mac_result;
                default: ;
            endcase
        end
        if (cmd.cmp_en)
        begin
            case (cmd.uop.kind)
                pcd_pkg::K_CMP_A2:   a2_r1_reg   <= r1_lt_r2;
                pcd_pkg::K_CMP_HILL: hill_ok_reg <= lhs_lt_rhs;
                pcd_pkg::K_CMP_STEP: close_reg   <= close_now;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else if (cmd.set_start)
        begin
            any_reg <= 1'b0;
        end
        else if (cmd.cmp_en && (cmd.uop.kind == pcd_pkg::K_CMP_STEP))
        begin
            any_reg <= any_reg | close_now;
        end
    end

    // result register
    pcd_pkg::out_item_t out_reg;
    logic [63:0]        dsat;

    assign dsat = (|d2_reg[pcd_pkg::BIG_W-1:64]) ? '1 : d2_reg[63:0];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_empty)
            begin
                out_reg.first_index      <= '0;
                out_reg.second_index     <= '0;
                out_reg.distance_squared <= '0;
                out_reg.close_flag       <= 1'b0;
                out_reg.any_close        <= 1'b0;
                out_reg.pair_valid       <= 1'b0;
                out_reg.last_pair        <= 1'b1;
            end
            else
            begin
                out_reg.first_index      <= pcd_pkg::OUT_IDX_W'(cmd.pair_i);
                out_reg.second_index     <= pcd_pkg::OUT_IDX_W'(cmd.pair_j);
                out_reg.distance_squared <= dsat;
                out_reg.close_flag       <= close_reg;
                out_reg.any_close        <= any_reg;
                out_reg.pair_valid       <= 1'b1;
                out_reg.last_pair        <= cmd.out_last;
            end
        end
    end

    assign out_data        = out_reg;
    assign status.mac_busy = mac_busy;
    assign status.mac_done = mac_done;

endmodule

// ===== hw/rtl/pcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcd controller
// load, central search, pair walk and result handoff sequencing
// ----------------------------------------------------------------------------
module pcd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   last_body,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pcd_pkg::ctrl_cmd_t     cmd,
    input  pcd_pkg::ctrl_status_t  status
);

    pcd_pkg::state_t            state_reg, state_next;
    logic [pcd_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [pcd_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [pcd_pkg::CNT_W-1:0]  scan_reg, scan_next;
    logic [pcd_pkg::CNT_W-1:0]  i_reg, i_next;
    logic [pcd_pkg::CNT_W-1:0]  j_reg, j_next;
    logic [pcd_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;

    logic [pcd_pkg::CNT_W-1:0] n_m1;
    logic                      empty_set;
    logic                      last_res;
    logic                      slot_free;

    assign n_m1      = n_reg - pcd_pkg::CNT_W'(1);
    assign empty_set = (n_reg < pcd_pkg::CNT_W'(2));
    assign last_res  = empty_set
                       || ((i_reg == n_reg - pcd_pkg::CNT_W'(2)) && (j_reg == n_m1));
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        scan_next      = scan_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;

        cmd            = '0;
        cmd.load_idx   = count_reg[pcd_pkg::IDX_W-1:0];
        cmd.scan_idx   = scan_reg[pcd_pkg::IDX_W-1:0];
        cmd.pair_i     = i_reg[pcd_pkg::IDX_W-1:0];
        cmd.pair_j     = j_reg[pcd_pkg::IDX_W-1:0];
        cmd.uop        = pcd_pkg::ucode(step_reg);
        cmd.out_empty  = empty_set;
        cmd.out_last   = last_res;

        case (state_reg)
            pcd_pkg::S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (count_reg < pcd_pkg::CNT_W'(pcd_pkg::MAX_BODIES))
                    begin
                        cmd.load_we = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    if (last_body)
                    begin
                        n_next     = count_next;
                        count_next = '0;
                        state_next = pcd_pkg::S_START;
                    end
                end
            end
            pcd_pkg::S_START:
            begin
                cmd.set_start = 1'b1;
                scan_next     = '0;
                state_next    = empty_set ? pcd_pkg::S_EMIT : pcd_pkg::S_SCAN_RD;
            end
            pcd_pkg::S_SCAN_RD:
            begin
                cmd.rd_addr = scan_reg[pcd_pkg::IDX_W-1:0];
                state_next  = pcd_pkg::S_SCAN_CMP;
            end
            pcd_pkg::S_SCAN_CMP:
            begin
                cmd.scan_cmp   = 1'b1;
                cmd.scan_first = (scan_reg == '0);
                if (scan_reg == n_m1)
                begin
                    i_next     = '0;
                    j_next     = pcd_pkg::CNT_W'(1);
                    state_next = pcd_pkg::S_RD_I;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = pcd_pkg::S_SCAN_RD;
                end
            end
            pcd_pkg::S_RD_I:
            begin
                cmd.rd_addr = i_reg[pcd_pkg::IDX_W-1:0];
                state_next  = pcd_pkg::S_LAT_I;
            end
            pcd_pkg::S_LAT_I:
            begin
                cmd.latch_i = 1'b1;
                cmd.rd_addr = j_reg[pcd_pkg::IDX_W-1:0];
                state_next  = pcd_pkg::S_LAT_J;
            end
            pcd_pkg::S_LAT_J:
            begin
                cmd.latch_j = 1'b1;
                step_next   = '0;
                state_next  = pcd_pkg::S_STEP;
            end
            pcd_pkg::S_STEP:
            begin
                if (cmd.uop.kind == pcd_pkg::K_MAC)
                begin
                    cmd.mac_start = 1'b1;
                    state_next    = pcd_pkg::S_MAC_WAIT;
                end
                else
                begin
                    cmd.cmp_en = 1'b1;
                    if (step_reg == pcd_pkg::STEP_W'(pcd_pkg::NUM_STEPS - 1))
                    begin
                        state_next = pcd_pkg::S_EMIT;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            pcd_pkg::S_MAC_WAIT:
            begin
                if (status.mac_done)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = pcd_pkg::S_STEP;
                end
            end
            pcd_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    if (last_res)
                    begin
                        state_next = pcd_pkg::S_LOAD;
                    end
                    else
                    begin
                        if (j_reg == n_m1)
                        begin
                            i_next = i_reg + 1'b1;
                            j_next = i_reg + pcd_pkg::CNT_W'(2);
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        state_next = pcd_pkg::S_RD_I;
                    end
                end
            end
            default:
            begin
                state_next = pcd_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcd_pkg::S_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            scan_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            scan_reg      <= scan_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/pairwise_close_encounter_detector_top.sv =====
// ----------------------------------------------------------------------------
// pairwise close encounter detector
// hill radius and step distance check over every pair of a loaded body set
// ----------------------------------------------------------------------------
//
//  channel   signals                          beat carries
//  -------   ------------------------------   ------------------------------
//  in        in_valid / in_stall / in_data    one body, last_body ends set
//  out       out_valid / out_stall / out_data one pair result
//  config    wr_en / wr_index / wr_data       hill, step factor, time step
//
// a body beat is taken every cycle while loading; the last beat starts the
// check: a central search over the loaded bodies, then each pair in turn on
// the single 32x32 limb multiplier, which runs 28 wide multiply-accumulates
// per pair. input is stalled from the last body until the final result is
// in the output register. the output register holds a result under
// out_stall while the next pair is worked on. reset clears control and the
// config registers; the body store needs no clearing pass.
// ----------------------------------------------------------------------------
module pairwise_close_encounter_detector_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // body input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  pcd_pkg::in_item_t               in_data,
    // pair results
    output logic                            out_valid,
    input  logic                            out_stall,
    output pcd_pkg::out_item_t              out_data,
    // config writes
    input  logic                            wr_en,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0]  wr_data
);

    `include "pairwise_close_encounter_detector_top_assert.svh"

    // command and status between sequencer and datapath
    pcd_pkg::ctrl_cmd_t    cmd;
    pcd_pkg::ctrl_status_t status;

    // sequencer: load count, central scan, pair indices, op steps
    pcd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_body (in_data.last_body),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: body store, wide arithmetic, compares, result register
    pcd_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

    // pair results come out in increasing index order
    `PCD_ASSERT_SAME(a_pair_order, out_valid && out_data.pair_valid,
        out_data.first_index < out_data.second_index)

    // an empty set gives one final, unflagged beat
    `PCD_ASSERT_SAME(a_empty_result, out_valid && !out_data.pair_valid,
        out_data.last_pair && !out_data.close_flag && !out_data.any_close)

    // a close pair is always reflected in the running flag
    `PCD_ASSERT_SAME(a_any_close, out_valid && out_data.close_flag, out_data.any_close)

    // no body is taken while the multiplier works on a pair
    `PCD_ASSERT_SAME(a_no_load_busy, status.mac_busy, in_stall)

    // a multiply is never restarted before it finishes
    `PCD_ASSERT_NEXT(a_mac_start, cmd.mac_start, status.mac_busy && !cmd.mac_start)

endmodule

// ===== bench/encounter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// close encounter result checker
// watches the body, result and register channels of the detector, works out
// the pair results of every body set on its own and compares them in order
// ----------------------------------------------------------------------------
module encounter_checker
    import pcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output int                    errors,
    output int                    pending,
    output int                    bodies_seen,
    output int                    pairs_seen,
    output int                    close_seen
);

    typedef bit [383:0] wide_t;

    bit [7:0]         hill_q44;
    bit [7:0]         step_q44;
    bit [31:0]        dt_q824;
    bit signed [31:0] px [MAX_BODIES];
    bit signed [31:0] py [MAX_BODIES];
    bit signed [31:0] pz [MAX_BODIES];
    bit signed [31:0] vx [MAX_BODIES];
    bit signed [31:0] vy [MAX_BODIES];
    bit signed [31:0] vz [MAX_BODIES];
    bit [31:0]        mass [MAX_BODIES];
    int               loaded;
    out_item_t        pair_queue [$];

    assign pending = pair_queue.size();

    function automatic wide_t square_sum(longint a, longint b, longint c);
        bit [63:0] ma;
        bit [63:0] mb;
        bit [63:0] mc;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        mc = c < 0 ? -c : c;
        return wide_t'(ma) * wide_t'(ma) + wide_t'(mb) * wide_t'(mb)
            + wide_t'(mc) * wide_t'(mc);
    endfunction

    function automatic bit encounter(int i, int j, wide_t d2, bit [31:0] mc);
        wide_t r1;
        wide_t r2;
        wide_t a2;
        wide_t v2;
        wide_t lhs;
        wide_t rhs;
        wide_t h3;
        wide_t msum;
        wide_t mcw;
        if (mc == 0)
            return 1'b0;
        r1 = square_sum(px[i], py[i], pz[i]);
        r2 = square_sum(px[j], py[j], pz[j]);
        a2 = (r1 < r2) ? r1 : r2;
        msum = wide_t'(mass[i]) + wide_t'(mass[j]);
        mcw = wide_t'(mc);
        h3 = wide_t'(hill_q44) * wide_t'(hill_q44) * wide_t'(hill_q44);
        // hill test, cubed on both sides
        lhs = d2 * d2 * d2 * wide_t'(9) * mcw * mcw * (wide_t'(1) << 24);
        rhs = a2 * a2 * a2 * h3 * h3 * msum * msum;
        if (lhs >= rhs)
            return 1'b0;
        // step distance test, squared
        v2 = square_sum(longint'(vx[i]) - longint'(vx[j]),
                        longint'(vy[i]) - longint'(vy[j]),
                        longint'(vz[i]) - longint'(vz[j]));
        lhs = d2 << 56;
        rhs = v2 * wide_t'(dt_q824) * wide_t'(dt_q824)
            * wide_t'(step_q44) * wide_t'(step_q44);
        return lhs < rhs;
    endfunction

    task automatic predict_set();
        int        n;
        int        hub;
        bit [31:0] mc;
        bit        any;
        wide_t     d2;
        out_item_t r;
        n = loaded;
        loaded = 0;
        if (n < 2)
        begin
            r = '0;
            r.last_pair = 1'b1;
            pair_queue.push_back(r);
            return;
        end
        hub = 0;
        mc = mass[0];
        for (int k = 1; k < n; k++)
            if (mass[k] > mc)
            begin
                mc = mass[k];
                hub = k;
            end
        any = 1'b0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
            begin
                d2 = square_sum(longint'(px[i]) - longint'(px[j]),
                                longint'(py[i]) - longint'(py[j]),
                                longint'(pz[i]) - longint'(pz[j]));
                r = '0;
                r.first_index = i[2:0];
                r.second_index = j[2:0];
                r.distance_squared = (d2 >> 64) != 0 ? '1 : d2[63:0];
                if (i != hub && j != hub)
                    r.close_flag = encounter(i, j, d2, mc);
                any |= r.close_flag;
                r.any_close = any;
                r.pair_valid = 1'b1;
                r.last_pair = (i == n - 2 && j == n - 1);
                pair_queue.push_back(r);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hill_q44 <= HILL_RESET;
            step_q44 <= STEP_RESET;
            dt_q824 <= TSTEP_RESET;
            loaded = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (cfg_reg_t'(wr_index))
                    REG_HILL_FACTOR: hill_q44 <= wr_data[7:0];
                    REG_STEP_FACTOR: step_q44 <= wr_data[7:0];
                    REG_TIME_STEP:   dt_q824 <= wr_data;
                    default: ;
                endcase
            end
            // body beat: store it, and a last body closes the set
            if (in_valid && !in_stall)
            begin
                bodies_seen++;
                if (loaded < MAX_BODIES)
                begin
                    px[loaded] = in_data.pos_x;
                    py[loaded] = in_data.pos_y;
                    pz[loaded] = in_data.pos_z;
                    vx[loaded] = in_data.vel_x;
                    vy[loaded] = in_data.vel_y;
                    vz[loaded] = in_data.vel_z;
                    mass[loaded] = in_data.body_mass;
                    loaded++;
                end
                if (in_data.last_body)
                    predict_set();
            end
            // result beat: compare against the oldest predicted pair
            if (out_valid && !out_stall)
            begin
                out_item_t e;
                pairs_seen++;
                if (out_data.close_flag)
                    close_seen++;
                if (pair_queue.size() == 0)
                begin
                    $error("unexpected result beat %p", out_data);
                    errors++;
                end
                else
                begin
                    e = pair_queue.pop_front();
                    if (out_data.first_index !== e.first_index)
                    begin
                        $error("first_index exp %0d got %0d", e.first_index,
                               out_data.first_index);
                        errors++;
                    end
                    if (out_data.second_index !== e.second_index)
                    begin
                        $error("second_index exp %0d got %0d", e.second_index,
                               out_data.second_index);
                        errors++;
                    end
                    if (out_data.distance_squared !== e.distance_squared)
                    begin
                        $error("distance_squared exp %h got %h", e.distance_squared,
                               out_data.distance_squared);
                        errors++;
                    end
                    if (out_data.close_flag !== e.close_flag)
                    begin
                        $error("close_flag exp %0b got %0b", e.close_flag,
                               out_data.close_flag);
                        errors++;
                    end
                    if (out_data.any_close !== e.any_close)
                    begin
                        $error("any_close exp %0b got %0b", e.any_close,
                               out_data.any_close);
                        errors++;
                    end
                    if (out_data.pair_valid !== e.pair_valid)
                    begin
                        $error("pair_valid exp %0b got %0b", e.pair_valid,
                               out_data.pair_valid);
                        errors++;
                    end
                    if (out_data.last_pair !== e.last_pair)
                    begin
                        $error("last_pair exp %0b got %0b", e.last_pair,
                               out_data.last_pair);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        bodies_seen = 0;
        pairs_seen = 0;
        close_seen = 0;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// close encounter detector testbench
// feeds body sets under several register settings and idle patterns; the
// checker beside the block predicts every pair result and counts mismatches
// ----------------------------------------------------------------------------
module testbench;
    import pcd_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    int errors;
    int pending;
    int bodies_seen;
    int pairs_seen;
    int close_seen;

    // idle pattern: percent of cycles the sender idles / receiver stalls
    int send_idle_pct;
    int recv_stall_pct;
    // long hold-off request, a new tag asks the receiver for one
    int hold_tag;
    int hold_seen;
    int hold_left;
    int random_bodies;

    pairwise_close_encounter_detector_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    encounter_checker check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .errors     (errors),
        .pending    (pending),
        .bodies_seen(bodies_seen),
        .pairs_seen (pairs_seen),
        .close_seen (close_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls, plus a long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_tag != hold_seen)
        begin
            hold_seen <= hold_tag;
            hold_left <= 3000;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #60ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // one body beat; in_valid stays high across back-to-back beats
    task automatic send_body(in_item_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // registers change only with the block idle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_regs(logic [7:0] hill, logic [7:0] stp, logic [31:0] dt);
        wr_en <= 1'b1;
        wr_index <= REG_HILL_FACTOR;
        wr_data <= {24'd0, hill};
        @(posedge clk);
        wr_index <= REG_STEP_FACTOR;
        wr_data <= {24'd0, stp};
        @(posedge clk);
        wr_index <= REG_TIME_STEP;
        wr_data <= dt;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic in_item_t make_body(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, logic signed [31:0] v,
                                           logic [31:0] m, logic lastb);
        in_item_t b;
        b = '0;
        b.pos_x = x;
        b.pos_y = y;
        b.pos_z = z;
        b.vel_x = v;
        b.vel_y = -v;
        b.vel_z = v >>> 1;
        b.body_mass = m;
        b.last_body = lastb;
        return b;
    endfunction

    // a cluster around a ring position, central body heavy; some pure noise
    task automatic random_set();
        int        n;
        int        sel;
        int        hub;
        in_item_t  b;
        int signed base;
        sel = $urandom_range(99);
        if (sel < 10)
            n = 1;
        else if (sel < 20)
            n = $urandom_range(8, 10);
        else
            n = $urandom_range(2, 5);
        hub = $urandom_range(n - 1);
        base = $urandom_range(2000, 200) <<< 16;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 20)
            begin
                b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, 1'b0};
            end
            else
            begin
                b.pos_x = base + ($urandom_range(400) << 14);
                b.pos_y = $urandom_range(400) << 14;
                b.pos_z = -($urandom_range(400) << 14);
                b.vel_x = $urandom_range(100 << 16);
                b.vel_y = -$urandom_range(100 << 16);
                b.vel_z = $urandom_range(1 << 20);
                b.body_mass = (k == hub) ? (32'h4000_0000 | $urandom_range(1 << 20))
                                         : $urandom_range(1 << 20);
            end
            b.last_body = (k == n - 1);
            send_body(b);
            random_bodies++;
        end
    endtask

    initial
    begin
        logic [7:0]  hills [4];
        logic [7:0]  steps [4];
        logic [31:0] dts   [4];
        rst_n = 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_stall <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= REG_HILL_FACTOR;
        wr_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_tag = 0;
        hold_seen = 0;
        hold_left = 0;
        random_bodies = 0;
        hills = '{8'd48, 8'd255, 8'd0, 8'd16};
        steps = '{8'd48, 8'd0, 8'd255, 8'd200};
        dts = '{32'h0100_0000, 32'hFFFF_FFFF, 32'd0, 32'h0080_0000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers first
        // lone body gives the empty result
        send_body(make_body(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 32'hFFFF_FFFF, 1'b1));
        // close pair next to a heavy central body
        send_body(make_body(0, 0, 0, 0, 32'd1_000_000, 1'b0));
        send_body(make_body(32'sd100 <<< 16, 0, 0, 32'sd1 <<< 16, 32'd1000, 1'b0));
        send_body(make_body((32'sd100 <<< 16) + 1, 0, 0, -(32'sd1 <<< 16),
                            32'd1000, 1'b1));
        // extreme corners, distance saturates; equal masses pick the first
        send_body(make_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_body(make_body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 32'hFFFF_FFFF, 1'b1));
        // all masses zero: nothing flagged; body at the origin too
        send_body(make_body(0, 0, 0, 32'sd5 <<< 16, 0, 1'b0));
        send_body(make_body(32'sd3, 0, 0, 0, 0, 1'b0));
        send_body(make_body(32'sd4, 0, 0, 0, 0, 1'b1));
        // more than the store holds; the tail bodies are dropped
        for (int k = 0; k < 10; k++)
            send_body(make_body(k <<< 12, -(k <<< 12), k, k <<< 16,
                                k == 4 ? 32'hFFFF : k, k == 9));

        // phases: register setting and idle pattern vary together
        for (int p = 0; p < 8; p++)
        begin
            settle();
            set_regs(hills[p % 4], steps[(p + 1) % 4], dts[p % 4]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct = 31;
                    recv_stall_pct = 31;
                end
            endcase
            // long receiver hold-off while bodies keep coming
            if (p == 2)
                hold_tag = hold_tag + 1;
            while (random_bodies < (p + 1) * 11)
                random_set();
        end

        settle();
        repeat (200) @(posedge clk);
        $display("run: %0d body beats, %0d pair results, %0d flagged close",
                 bodies_seen, pairs_seen, close_seen);
        $display("register settings and four idle patterns, with one long hold-off");
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_mac.sv
hw/rtl/pcd_datapath.sv
hw/rtl/pcd_ctrl.sv
hw/rtl/pairwise_close_encounter_detector_top.sv
bench/encounter_checker.sv
bench/testbench.sv
